// ----- sv/best_disjoint_pair_selector_unit_defines.svh -----
// assertion helpers used by the top-level rtl
`ifndef BEST_DISJOINT_PAIR_SELECTOR_UNIT_DEFINES_SVH
`define BEST_DISJOINT_PAIR_SELECTOR_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define BDPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define BDPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bdps_pkg.sv -----
package bdps_pkg;

  localparam int MAX_PAIRS = 16;
  localparam int IDX_W     = $clog2(MAX_PAIRS);
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int SCORE_W   = 16;
  localparam int MEMBER_W  = 4;

  typedef logic signed [1:0] label_t;

  localparam label_t LABEL_NONE   = 2'sb11;
  localparam label_t LABEL_FIRST  = 2'sb00;
  localparam label_t LABEL_SECOND = 2'sb01;

  // copy of a pair that travels around the ring
  typedef struct packed {
    logic                valid;
    logic [IDX_W-1:0]    idx;
    logic [SCORE_W-1:0]  score;
    logic [MEMBER_W-1:0] member_a;
    logic [MEMBER_W-1:0] member_b;
    logic [IDX_W-1:0]    rank;
  } token_t;

  // sequencer strobes common to all cells
  typedef struct packed {
    logic tok_load;
    logic clr;
    logic rank_en;
    logic part_en;
  } cell_ctrl_t;

  // per-cell result of the two ring passes
  typedef struct packed {
    logic [IDX_W-1:0] rank;
    logic             has_partner;
    logic [IDX_W-1:0] partner_rank;
  } cell_stat_t;

endpackage

// ----- sv/bdps_cell.sv -----
module bdps_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bdps_pkg::IDX_W-1:0]    cell_idx,
  input  logic                          home_valid,
  input  logic                          wr_en,
  input  logic [bdps_pkg::SCORE_W-1:0]  wr_score,
  input  logic [bdps_pkg::MEMBER_W-1:0] wr_member_a,
  input  logic [bdps_pkg::MEMBER_W-1:0] wr_member_b,
  input  bdps_pkg::cell_ctrl_t          ctrl,
  input  bdps_pkg::token_t              tok_in,
  output bdps_pkg::token_t              tok_out,
  output bdps_pkg::cell_stat_t          stat
);

  logic [bdps_pkg::SCORE_W-1:0]  score_r;
  logic [bdps_pkg::MEMBER_W-1:0] member_a_r;
  logic [bdps_pkg::MEMBER_W-1:0] member_b_r;
  logic [bdps_pkg::IDX_W-1:0]    rank_r;
  logic                          has_r;
  logic [bdps_pkg::IDX_W-1:0]    best_r;
  bdps_pkg::token_t              tok_r;

  logic ahead;
  logic disjoint;
  logic better;

  // visiting pair ranks ahead of the home pair
  assign ahead = tok_r.valid &&
                 ((tok_r.score > score_r) ||
                  ((tok_r.score == score_r) && (tok_r.idx < cell_idx)));

  assign disjoint = (tok_r.member_a != member_a_r) && (tok_r.member_a != member_b_r) &&
                    (tok_r.member_b != member_a_r) && (tok_r.member_b != member_b_r);

  assign better = home_valid && tok_r.valid && (tok_r.rank > rank_r) && disjoint &&
                  (!has_r || (tok_r.rank < best_r));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      score_r    <= wr_score;
      member_a_r <= wr_member_a;
      member_b_r <= wr_member_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= '0;
      rank_r <= '0;
      has_r  <= 1'b0;
      best_r <= '0;
    end else begin
      if (ctrl.tok_load) begin
        tok_r.valid    <= home_valid;
        tok_r.idx      <= cell_idx;
        tok_r.score    <= score_r;
        tok_r.member_a <= member_a_r;
        tok_r.member_b <= member_b_r;
        tok_r.rank     <= rank_r;
      end else if (ctrl.rank_en || ctrl.part_en) begin
        tok_r <= tok_in;
      end
      if (ctrl.clr) begin
        rank_r <= '0;
        has_r  <= 1'b0;
      end else if (ctrl.rank_en && ahead) begin
        rank_r <= rank_r + bdps_pkg::IDX_W'(1);
      end
      if (ctrl.part_en && better) begin
        has_r  <= 1'b1;
        best_r <= tok_r.rank;
      end
    end
  end

  assign tok_out           = tok_r;
  assign stat.rank         = rank_r;
  assign stat.has_partner  = has_r;
  assign stat.partner_rank = best_r;

endmodule

// ----- sv/best_disjoint_pair_selector_unit.sv -----
// channel  | ports                                                               | direction
// ---------+---------------------------------------------------------------------+----------
// in       | in_valid in_stall in_score in_member_a in_member_b in_last_in_event | to block
// out      | out_valid out_stall out_label out_overflowed out_last_label         | from block
//
// an event of n pairs loads one beat per cycle, then goes through the ring rotation
// (ranking pass and partner pass), a scan of the n pairs and n label beats
// rst_n is synchronous; it empties the event and drops any pending label beat
// out_stall holds the label register and pauses the label walk; the next event loads
// while the final label beat still waits
`include "best_disjoint_pair_selector_unit_defines.svh"

module best_disjoint_pair_selector_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bdps_pkg::SCORE_W-1:0]  in_score,
  input  logic [bdps_pkg::MEMBER_W-1:0] in_member_a,
  input  logic [bdps_pkg::MEMBER_W-1:0] in_member_b,
  input  logic                          in_last_in_event,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bdps_pkg::label_t              out_label,
  output logic                          out_overflowed,
  output logic                          out_last_label
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RLOAD,
    ST_RANK,
    ST_PLOAD,
    ST_PART,
    ST_SCAN,
    ST_OUT
  } state_t;

  localparam int N = bdps_pkg::MAX_PAIRS;

  state_t                     state_r, state_nxt;
  logic [bdps_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [bdps_pkg::IDX_W-1:0] step_r, step_nxt;
  logic                       found_r, found_nxt;
  logic [bdps_pkg::IDX_W-1:0] r1_r, r1_nxt;
  logic [bdps_pkg::IDX_W-1:0] r2_r, r2_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bdps_pkg::label_t           out_label_r, out_label_nxt;
  logic                       out_ovf_r, out_ovf_nxt;
  logic                       out_last_r, out_last_nxt;

  bdps_pkg::cell_ctrl_t       ctrl;
  bdps_pkg::token_t           tok_out [N];
  bdps_pkg::cell_stat_t       stat    [N];
  bdps_pkg::cell_stat_t       cur;

  logic in_fire;
  logic last_idx;
  logic emit;
  logic ring_end;

  assign in_stall = (state_r != ST_LOAD);
  assign in_fire  = in_valid && !in_stall;

  // stats of the cell under the walk pointer
  assign cur      = stat[step_r];
  assign last_idx = (bdps_pkg::CNT_W'(step_r) == (count_r - bdps_pkg::CNT_W'(1)));
  assign ring_end = (step_r == bdps_pkg::IDX_W'(N - 1));

  // ring of cells, each token moves one cell forward per cycle during the ranking and partner passes
  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam int PREV = (k + N - 1) % N;
    bdps_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (bdps_pkg::IDX_W'(k)),
      .home_valid  (bdps_pkg::CNT_W'(k) < count_r),
      .wr_en       (in_fire && (count_r == bdps_pkg::CNT_W'(k))),
      .wr_score    (in_score),
      .wr_member_a (in_member_a),
      .wr_member_b (in_member_b),
      .ctrl        (ctrl),
      .tok_in      (tok_out[PREV]),
      .tok_out     (tok_out[k]),
      .stat        (stat[k])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    step_nxt      = step_r;
    found_nxt     = found_r;
    r1_nxt        = r1_r;
    r2_nxt        = r2_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_label_nxt = out_label_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;
    emit          = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          // full event drops the pair and remembers the overflow
          if (count_r == bdps_pkg::CNT_W'(N)) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + bdps_pkg::CNT_W'(1);
          end
          if (in_last_in_event) begin
            state_nxt = ST_RLOAD;
          end
        end
      end
      ST_RLOAD: begin
        ctrl.tok_load = 1'b1;
        ctrl.clr      = 1'b1;
        step_nxt      = '0;
        state_nxt     = ST_RANK;
      end
      ST_RANK: begin
        // each cell counts visitors that rank ahead of it
        ctrl.rank_en = 1'b1;
        step_nxt     = step_r + bdps_pkg::IDX_W'(1);
        if (ring_end) begin
          step_nxt  = '0;
          state_nxt = ST_PLOAD;
        end
      end
      ST_PLOAD: begin
        // reload tokens, now carrying the ranks
        ctrl.tok_load = 1'b1;
        found_nxt     = 1'b0;
        state_nxt     = ST_PART;
      end
      ST_PART: begin
        // each cell keeps its earliest later-ranked disjoint partner
        ctrl.part_en = 1'b1;
        step_nxt     = step_r + bdps_pkg::IDX_W'(1);
        if (ring_end) begin
          step_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // best-ranked pair that has a partner wins
        if (cur.has_partner && (!found_r || (cur.rank < r1_r))) begin
          found_nxt = 1'b1;
          r1_nxt    = cur.rank;
          r2_nxt    = cur.partner_rank;
        end
        step_nxt = step_r + bdps_pkg::IDX_W'(1);
        if (last_idx) begin
          step_nxt  = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          emit          = 1'b1;
          out_valid_nxt = 1'b1;
          if (found_r && (cur.rank == r1_r)) begin
            out_label_nxt = bdps_pkg::LABEL_FIRST;
          end else if (found_r && (cur.rank == r2_r)) begin
            out_label_nxt = bdps_pkg::LABEL_SECOND;
          end else begin
            out_label_nxt = bdps_pkg::LABEL_NONE;
          end
          out_ovf_nxt  = ovf_r;
          out_last_nxt = last_idx;
          step_nxt     = step_r + bdps_pkg::IDX_W'(1);
          if (last_idx) begin
            // event done, clear it for the next one
            step_nxt  = '0;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      step_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    r1_r        <= r1_nxt;
    r2_r        <= r2_nxt;
    out_label_r <= out_label_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_label      = out_label_r;
  assign out_overflowed = out_ovf_r;
  assign out_last_label = out_last_r;

  `BDPS_ASSERT_SAME(a_count_bound, 1'b1, count_r <= bdps_pkg::CNT_W'(N), "pair count overran")
  `BDPS_ASSERT_SAME(a_partner_later, (state_r == ST_OUT) && found_r, r2_r > r1_r, "partner not later")
  `BDPS_ASSERT_NEXT(a_event_clear, emit && last_idx, (count_r == '0) && !ovf_r, "event not cleared")

endmodule
